FILE: rtl/core/sidta_pkg.sv
// Shared types, character codes and decimal constants for the integer-to-text converter.
`timescale 1ns / 1ps

package sidta_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned WIDE_W  = 34;
    localparam int unsigned MAX_POS = 9;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic negative;
        logic last_digit;
        logic out_free;
    } status_t;

    // Power of ten for a decimal position, wide enough for nine times the largest one.
    function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [WIDE_W-1:0] result;
        unique case (pos)
            4'd0:    result = 34'd1;
            4'd1:    result = 34'd10;
            4'd2:    result = 34'd100;
            4'd3:    result = 34'd1000;
            4'd4:    result = 34'd10000;
            4'd5:    result = 34'd100000;
            4'd6:    result = 34'd1000000;
            4'd7:    result = 34'd10000000;
            4'd8:    result = 34'd100000000;
            4'd9:    result = 34'd1000000000;
            default: result = 34'd0;
        endcase
        return result;
    endfunction

endpackage

FILE: rtl/core/sidta_ctrl.sv
// Sequencing state machine for the integer-to-text converter.
`timescale 1ns / 1ps

module sidta_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sidta_pkg::status_t status,
    output sidta_pkg::cmd_t    cmd
);
    import sidta_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/sidta_datapath.sv
// Magnitude, digit extraction and output register of the integer-to-text converter.
`timescale 1ns / 1ps

module sidta_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sidta_pkg::cmd_t                cmd,
    output sidta_pkg::status_t             status,
    input  logic [sidta_pkg::VALUE_W-1:0]  value,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sidta_pkg::CHAR_W-1:0]   m_tdata,
    output logic                           m_tlast
);
    import sidta_pkg::*;

    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic               neg_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;

    logic [POS_W-1:0]   ndig_pos;
    logic [WIDE_W-1:0]  rem_wide;
    logic [WIDE_W-1:0]  mult [1:MAX_POS];
    logic [POS_W-1:0]   digit;
    logic [WIDE_W-1:0]  sub;
    logic [WIDE_W-1:0]  rem_diff;

    assign rem_wide = {{(WIDE_W-VALUE_W){1'b0}}, rem_reg};

    // Position of the leading digit: how many powers of ten the magnitude reaches.
    always_comb
    begin
        ndig_pos = '0;
        for (int i = 1; i <= MAX_POS; i++)
        begin
            if (rem_wide >= pow10(POS_W'(i)))
            begin
                ndig_pos = ndig_pos + 1'b1;
            end
        end
    end

    // Digit at the current position from the multiples of its power of ten.
    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int k = 1; k <= MAX_POS; k++)
        begin
            mult[k] = WIDE_W'(k) * pow10(pos_reg);
            if (rem_wide >= mult[k])
            begin
                digit = POS_W'(k);
                sub   = mult[k];
            end
        end
    end

    assign rem_diff = rem_wide - sub;

    always_comb
    begin
        rem_next = rem_reg;
        pos_next = pos_reg;
        if (cmd.load)
        begin
            rem_next = value[VALUE_W-1] ? (~value + 1'b1) : value;
        end
        else if (cmd.setup)
        begin
            pos_next = ndig_pos;
        end
        else if (cmd.emit_digit)
        begin
            rem_next = rem_diff[VALUE_W-1:0];
            pos_next = pos_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        pos_reg <= pos_next;
        if (cmd.load)
        begin
            neg_reg <= value[VALUE_W-1];
        end
        if (cmd.emit_sign)
        begin
            out_char_reg <= ASCII_MINUS;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_char_reg <= ASCII_ZERO + {{(CHAR_W-POS_W){1'b0}}, digit};
            out_last_reg <= (pos_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.negative   = neg_reg;
    assign status.last_digit = (pos_reg == '0);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Each input transaction carries one two's complement integer; the block answers with its
// decimal text, one character per output transaction, most significant first, with a
// leading '-' for negative values, no leading zeros, a single '0' for zero, and tlast on
// the final character. A value is accepted, then its leading digit is searched, then its
// characters are sent in order; while the sink is ready, the digit loop produces one digit
// per cycle by comparing the remainder against the nine multiples of
// the current power of ten. The next value is accepted while the last character still
// waits in the output register.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character[7:0]
    output logic        m_tlast
);
    import sidta_pkg::*;

    cmd_t    cmd;
    status_t status;

    sidta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sidta_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .value    (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/core/sidta_checker.sv
// Port-level checker for the integer-to-text converter and its bind to the top level.
`timescale 1ns / 1ps

module sidta_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);
    import sidta_pkg::*;

    // A stalled output transaction keeps its character and flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    // Only a minus sign or a decimal digit is ever sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == ASCII_MINUS)
                     || ((m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_NINE)))
        else $error("output character is not a sign or digit");

    // The minus sign always has digits after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == ASCII_MINUS) |-> !m_tlast)
        else $error("minus sign flagged as last character");

    // A new value is not taken in the cycle right after one was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a conversion is starting");

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_checker (.*);
